// File: rtl/core/r2y_pkg.sv
// Shared constants and types for the RGB32 to YUYV 4:2:2 converter.
// No dependencies; every other file of the block but r2y_if imports this package.
package r2y_pkg;

  localparam int DIM_W         = 13;
  localparam int INDEX_W       = 23;
  localparam int PAIRS_W       = INDEX_W + 1;
  localparam int PIXEL_W       = 32;
  localparam int WORD_W        = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int MAX_DIMENSION = 4096;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [PAIRS_W-1:0] PAIRS_RESET =
    PAIRS_W'((640 / 2) * 480);
  localparam logic [PAIRS_W-1:0] PAIRS_SPAN = PAIRS_W'(1) << INDEX_W;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PAIRS_W-1:0] pairs;
    logic               empty;
  } frame_cfg_t;

endpackage

// File: rtl/core/r2y_if.sv
// Valid/ready channel interfaces for the pixel pair input and the YUYV result.
// Depends on nothing beyond plain logic vectors.
interface r2y_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_first;
  logic [31:0] pixel_second;

  modport source (output valid, output pixel_first, output pixel_second, input ready);
  modport sink   (input valid, input pixel_first, input pixel_second, output ready);
endinterface

interface r2y_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] yuyv_word;
  logic        last_of_frame;

  modport source (output valid, output yuyv_word, output last_of_frame, input ready);
  modport sink   (input valid, input yuyv_word, input last_of_frame, output ready);
endinterface

// File: rtl/core/r2y_cfg_regs.sv
// APB-style frame size registers and the registered pairs-per-frame value.
// Depends on r2y_pkg.
module r2y_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [r2y_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [r2y_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [r2y_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output r2y_pkg::frame_cfg_t              frame_cfg
);
  import r2y_pkg::*;

  localparam int PROD_W = 2 * DIM_W;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);

  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic [PAIRS_W-1:0] pairs_r, pairs_nxt;
  logic               empty_r, empty_nxt;
  logic               wr_en;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [PROD_W-1:0]  product;
  logic [PAIRS_W-1:0] pairs_raw;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_FRAME_WIDTH:  width_nxt  = cfg_pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_nxt = cfg_pwdata[DIM_W-1:0];
        default:          width_nxt  = width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_comb begin
    w_eff     = ((width_r > DIM_MAX) ? DIM_MAX : width_r) & ~DIM_W'(1);
    h_eff     = (height_r > DIM_MAX) ? DIM_MAX : height_r;
    product   = PROD_W'(w_eff) * PROD_W'(h_eff);
    pairs_raw = product[PAIRS_W:1];
    pairs_nxt = (pairs_raw > PAIRS_SPAN) ? PAIRS_SPAN : pairs_raw;
    empty_nxt = (pairs_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      pairs_r  <= PAIRS_RESET;
      empty_r  <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      pairs_r  <= pairs_nxt;
      empty_r  <= empty_nxt;
    end
  end

  assign frame_cfg.pairs = pairs_r;
  assign frame_cfg.empty = empty_r;

endmodule

// File: rtl/core/r2y_color_math.sv
// Luma and averaged chroma arithmetic for one pixel pair, packed as YUYV.
// Depends on r2y_pkg.
module r2y_color_math (
  input  logic [r2y_pkg::PIXEL_W-1:0] pixel_first,
  input  logic [r2y_pkg::PIXEL_W-1:0] pixel_second,
  output logic [r2y_pkg::WORD_W-1:0]  yuyv_word
);
  import r2y_pkg::*;

  localparam logic [15:0] BIAS = 16'd32768;

  logic [7:0]  b0, g0, r0, b1, g1, r1;
  logic [8:0]  bs, gs, rs;
  logic [7:0]  ba, ga, ra;
  logic [15:0] y0_sum, y1_sum, u_sum, v_sum;

  always_comb begin
    b0 = pixel_first[31:24];
    g0 = pixel_first[23:16];
    r0 = pixel_first[15:8];
    b1 = pixel_second[31:24];
    g1 = pixel_second[23:16];
    r1 = pixel_second[15:8];

    y0_sum = 16'd77 * 16'(r0) + 16'd150 * 16'(g0) + 16'd29 * 16'(b0);
    y1_sum = 16'd77 * 16'(r1) + 16'd150 * 16'(g1) + 16'd29 * 16'(b1);

    bs = 9'(b0) + 9'(b1);
    gs = 9'(g0) + 9'(g1);
    rs = 9'(r0) + 9'(r1);
    ba = bs[8:1];
    ga = gs[8:1];
    ra = rs[8:1];

    // The biased sums always land in 0..65535, so 16-bit wraparound is exact.
    u_sum = BIAS + (16'(ba) << 7) - 16'd43 * 16'(ra) - 16'd85 * 16'(ga);
    v_sum = BIAS + (16'(ra) << 7) - 16'd107 * 16'(ga) - 16'd21 * 16'(ba);

    yuyv_word = {y0_sum[15:8], u_sum[15:8], y1_sum[15:8], v_sum[15:8]};
  end

endmodule

// File: rtl/core/rgb32_to_yuyv422_converter_core.sv
// Top level of the RGB32 pixel pair to YUYV 4:2:2 converter.
// Depends on r2y_pkg, r2y_if, r2y_cfg_regs and r2y_color_math.
// An input register comes first, then the color arithmetic and frame counter feed the
// result register.
// Throughput is one item per cycle; the result register stalls only on out ready.
// Reset is synchronous and active low: it empties both stages, clears the pair counter and
// sets the frame size to 640 by 480.
module rgb32_to_yuyv422_converter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  r2y_in_if.sink                         in_chan,
  r2y_out_if.source                      out_chan,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [r2y_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [r2y_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [r2y_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import r2y_pkg::*;

  frame_cfg_t          frame_cfg;
  logic                s1_valid_r, s1_valid_nxt;
  logic [PIXEL_W-1:0]  s1_first_r, s1_second_r;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_word_r;
  logic                out_last_r;
  logic [INDEX_W-1:0]  pair_index_r, pair_index_nxt;
  logic [WORD_W-1:0]   word_calc;
  logic                in_ready;
  logic                in_take;
  logic                out_adv;
  logic                s1_adv;
  logic [PAIRS_W-1:0]  index_inc;
  logic                last_calc;

  r2y_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .frame_cfg   (frame_cfg)
  );

  r2y_color_math u_math (
    .pixel_first  (s1_first_r),
    .pixel_second (s1_second_r),
    .yuyv_word    (word_calc)
  );

  assign out_adv  = !out_valid_r || out_chan.ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_take  = in_chan.valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_chan.valid : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

    index_inc = PAIRS_W'(pair_index_r) + PAIRS_W'(1);
    last_calc = frame_cfg.empty || (index_inc >= frame_cfg.pairs);

    pair_index_nxt = pair_index_r;
    if (s1_adv) begin
      pair_index_nxt = last_calc ? '0 : index_inc[INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pair_index_r <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      pair_index_r <= pair_index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_first_r  <= in_chan.pixel_first;
      s1_second_r <= in_chan.pixel_second;
    end
    if (s1_adv) begin
      out_word_r <= word_calc;
      out_last_r <= last_calc;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.yuyv_word     = out_word_r;
  assign out_chan.last_of_frame = out_last_r;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgb32_to_yuyv422_converter_core: directed and random pixel pairs
// are checked item by item against an in-bench color converter and frame pair counter.
// Depends on r2y_pkg, the r2y_in_if and r2y_out_if interfaces and the converter RTL.
module testbench;
  import r2y_pkg::*;

  typedef struct packed {
    logic [PIXEL_W-1:0] first;
    logic [PIXEL_W-1:0] second;
  } pixel_pair_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } yuyv_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  r2y_in_if  in_if();
  r2y_out_if out_if();

  rgb32_to_yuyv422_converter_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pixel_pair_t  pairs_pending[$];
  yuyv_result_t yuyv_expected[$];

  int send_idle_pct   = 37;
  int recv_idle_pct   = 69;
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  int error_count     = 0;

  logic [DIM_W-1:0] width_mirror  = WIDTH_RESET;
  logic [DIM_W-1:0] height_mirror = HEIGHT_RESET;
  int unsigned      pair_idx      = 0;

  function automatic int unsigned frame_pair_total();
    int unsigned w;
    int unsigned h;
    int unsigned total;
    w = (width_mirror > MAX_DIMENSION) ? MAX_DIMENSION : width_mirror;
    w = w & ~32'd1;
    h = (height_mirror > MAX_DIMENSION) ? MAX_DIMENSION : height_mirror;
    total = (w * h) / 2;
    if (total > (32'd1 << INDEX_W)) total = 32'd1 << INDEX_W;
    return total;
  endfunction

  function automatic logic [7:0] luma_of(int r, int g, int b);
    int acc;
    acc = 77 * r + 150 * g + 29 * b;
    return acc[15:8];
  endfunction

  // Chroma is floor(sum / 256) + 128; the arithmetic shift gives the floor.
  function automatic logic [7:0] chroma_of(int sum);
    int c;
    c = (sum >>> 8) + 128;
    return c[7:0];
  endfunction

  function automatic yuyv_result_t convert_pair(pixel_pair_t p);
    yuyv_result_t res;
    int           r0, g0, b0, r1, g1, b1, ra, ga, ba;
    int unsigned  total;
    b0 = p.first[31:24];
    g0 = p.first[23:16];
    r0 = p.first[15:8];
    b1 = p.second[31:24];
    g1 = p.second[23:16];
    r1 = p.second[15:8];
    ra = (r0 + r1) >> 1;
    ga = (g0 + g1) >> 1;
    ba = (b0 + b1) >> 1;
    res.word = {luma_of(r0, g0, b0), chroma_of(-43 * ra - 85 * ga + 128 * ba),
                luma_of(r1, g1, b1), chroma_of(128 * ra - 107 * ga - 21 * ba)};
    total = frame_pair_total();
    if (total == 0 || pair_idx + 1 >= total) begin
      res.last = 1'b1;
      pair_idx = 0;
    end else begin
      res.last = 1'b0;
      pair_idx = pair_idx + 1;
    end
    return res;
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom;
    if ($urandom_range(99) < 30) begin
      for (int i = 1; i < 4; i++) begin
        case ($urandom_range(2))
          0: px[8*i +: 8] = 8'h00;
          1: px[8*i +: 8] = 8'hff;
          default: ;
        endcase
      end
    end
    return px;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin : drive_pairs
    pixel_pair_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        yuyv_expected.push_back(convert_pair({in_if.pixel_first, in_if.pixel_second}));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pairs_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pairs_pending.pop_front();
          in_if.valid        <= 1'b1;
          in_if.pixel_first  <= nxt.first;
          in_if.pixel_second <= nxt.second;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_words
    yuyv_result_t exp_res;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (yuyv_expected.size() == 0) begin
          $display("%0t: unexpected item, word %h last %b", $time, out_if.yuyv_word,
                   out_if.last_of_frame);
          error_count++;
        end else begin
          exp_res = yuyv_expected.pop_front();
          if (out_if.yuyv_word !== exp_res.word) begin
            $display("%0t: yuyv_word expected %h actual %h", $time, exp_res.word,
                     out_if.yuyv_word);
            error_count++;
          end
          if (out_if.last_of_frame !== exp_res.last) begin
            $display("%0t: last_of_frame expected %b actual %b", $time, exp_res.last,
                     out_if.last_of_frame);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (holds_served != holds_requested) begin
        holds_served <= holds_served + 1;
        hold_left    <= 300;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_register(input logic reg_sel, input logic [DIM_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({reg_sel, 2'b00});
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_sel == REG_FRAME_WIDTH) width_mirror = value;
    else height_mirror = value;
  endtask

  task automatic wait_idle();
    while (pairs_pending.size() != 0 || in_if.valid || yuyv_expected.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_idle();
    write_register(REG_FRAME_WIDTH, DIM_W'(w));
    write_register(REG_FRAME_HEIGHT, DIM_W'(h));
    @(negedge clk);
  endtask

  task automatic queue_pair(input logic [31:0] a, input logic [31:0] b);
    pairs_pending.push_back('{first: a, second: b});
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_pair(random_pixel(), random_pixel());
  endtask

  initial begin : stimulus
    int random_sent;
    int phase;
    int n;
    int unsigned w;
    int unsigned h;

    rst_n              = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_if.valid        = 1'b0;
    in_if.pixel_first  = '0;
    in_if.pixel_second = '0;
    out_if.ready       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Color extremes at the reset frame size.
    queue_pair(32'h0000_0000, 32'h0000_0000);
    queue_pair(32'hffff_ffff, 32'hffff_ffff);
    queue_pair(32'hff00_0000, 32'h00ff_0000);
    queue_pair(32'h0000_ff00, 32'h0000_00ff);
    queue_pair(32'hff00_00a5, 32'hff00_005a);
    queue_pair(32'h00ff_ff00, 32'h00ff_ff00);
    queue_pair(32'hffff_0000, 32'hffff_0000);
    queue_pair(32'h0101_0100, 32'h0000_0000);
    queue_pair(32'hffff_ff00, 32'h0000_00ff);
    queue_pair(32'h1234_5678, 32'h9abc_def0);

    // Empty frames, oversized dimensions and a frame that shrinks under the counter.
    set_frame(0, 480);
    queue_random(2);
    set_frame(1, 3);
    queue_random(2);
    set_frame(640, 0);
    queue_random(2);
    set_frame(8191, 8191);
    queue_random(2);
    set_frame(4096, 4096);
    queue_random(1);
    set_frame(4, 2);
    queue_random(3);
    set_frame(2, 1);
    queue_random(2);

    random_sent = 0;
    phase       = 0;
    while (random_sent < 1350) begin
      if (random_sent < 450) begin
        send_idle_pct = 37;
        recv_idle_pct = 69;
      end else if (random_sent < 900) begin
        send_idle_pct = 69;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(7))
          0: w = 0;
          1: w = 1;
          2: w = 3;
          3: w = 4096;
          4: w = 4097;
          5: w = 8191;
          default: w = 640;
        endcase
        case ($urandom_range(4))
          0: h = 0;
          1: h = 1;
          2: h = 4096;
          3: h = 8191;
          default: h = 480;
        endcase
      end else begin
        w = $urandom_range(0, 16);
        h = $urandom_range(0, 8);
      end
      set_frame(w, h);
      n = $urandom_range(10, 60);
      if (phase == 3) begin
        holds_requested = holds_requested + 1;
        n = 60;
        queue_random(n);
      end else if (phase == 6) begin
        queue_random(n / 2);
        wait_idle();
        queue_random(n - n / 2);
      end else begin
        queue_random(n);
      end
      random_sent = random_sent + n;
      phase = phase + 1;
    end

    wait_idle();
    if (error_count == 0 && yuyv_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
